@@ sv/cgl_pkg.sv @@
// ---------------------------------------------------------------------------
// cgl_pkg: shared types and constants of the coupled global/local LDPC encoder
// Holds request codes, table and vector indexes, status codes and the
// command and status structs between controller and datapath.
// ---------------------------------------------------------------------------
package cgl_pkg;

  localparam int unsigned MaxEntries    = 4096;
  localparam int unsigned MaxSourceBits = 4096;
  localparam int unsigned MaxParityBits = 1024;
  localparam int unsigned TableCount    = 5;

  localparam int unsigned EntryAw  = $clog2(MaxEntries);
  localparam int unsigned SrcAw    = $clog2(MaxSourceBits);
  localparam int unsigned ParAw    = $clog2(MaxParityBits);
  localparam int unsigned CountW   = EntryAw + 1;
  localparam int unsigned TabAw    = 3;
  localparam int unsigned MemAw    = TabAw + EntryAw;
  localparam int unsigned EntryW   = ParAw + SrcAw;
  localparam int unsigned LenW     = 11;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // Request codes.
  localparam logic [2:0] ReqLoadEntry = 3'd0;
  localparam logic [2:0] ReqLoadBit   = 3'd1;
  localparam logic [2:0] ReqEncode    = 3'd2;
  localparam logic [2:0] ReqRead      = 3'd3;
  localparam logic [2:0] ReqClear     = 3'd4;

  // Table indexes.
  localparam logic [2:0] TabV = 3'd0;
  localparam logic [2:0] TabW = 3'd1;
  localparam logic [2:0] TabX = 3'd2;
  localparam logic [2:0] TabY = 3'd3;
  localparam logic [2:0] TabZ = 3'd4;

  // Vector and read targets.
  localparam logic [2:0] VecSys    = 3'd0;
  localparam logic [2:0] VecFirst  = 3'd1;
  localparam logic [2:0] VecSecond = 3'd2;
  localparam logic [2:0] RdGlobal  = 3'd0;
  localparam logic [2:0] RdLocal   = 3'd1;

  // Status codes.
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgLocalCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGlobalLen  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLocalLen   = 2'd2;

  // Source of a parity accumulation pass.
  typedef enum logic [1:0] {
    SrcSys    = 2'd0,
    SrcFirst  = 2'd1,
    SrcSecond = 2'd2,
    SrcGlobal = 2'd3
  } src_sel_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic              clr_start;  // load clear index with zero
    logic              clr_step;   // clear one parity bit of both stores
    logic              rd_entry;   // read entry at table/index
    logic [2:0]        tab;
    logic [EntryAw-1:0] idx;
    logic              acc_en;     // set with rd_entry; unused by the datapath
    src_sel_e          src;
    logic              dst_local;
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

@@ sv/coupled_global_local_ldpc_encoder.sv @@
// ---------------------------------------------------------------------------
// coupled_global_local_ldpc_encoder: sparse GF(2) encoder, global + local
// Loads, reads and table clears give their result in the cycle after
// acceptance, one transaction per cycle unless an encode runs or the result
// side stalls. An encode clears the parity stores, then reads each table in
// use through the single entry-memory read port, draining after each pass.
// Reset clears entry counts and parity stores, presets config; data unknown.
// ---------------------------------------------------------------------------
module coupled_global_local_ldpc_encoder
  import cgl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          req_type_i,
  input  logic [2:0]          target_i,
  input  logic [11:0]         row_index_i,
  input  logic [11:0]         col_index_i,
  input  logic                bit_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                read_bit_o,
  output logic [1:0]          status_o
);

  // Configuration registers.
  logic [1:0]      local_count_q;
  logic [LenW-1:0] glen_q, llen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_count_q <= 2'd2;
      glen_q        <= LenW'(1024);
      llen_q        <= LenW'(1024);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgLocalCount: local_count_q <= cfg_data_i[1:0];
        CfgGlobalLen:  glen_q        <= cfg_data_i;
        CfgLocalLen:   llen_q        <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  cmd_t cmd;
  sts_t sts;
  logic ent_we, bit_we, rd_en, rd_pending, rd_bit;
  logic [EntryAw-1:0] ent_idx;

  cgl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .target_i,
    .row_index_i, .col_index_i, .out_valid_o, .out_stall_i, .status_o,
    .rd_pending_o(rd_pending), .local3_i(local_count_q == 2'd3),
    .glen_i(glen_q), .llen_i(llen_q), .cmd_o(cmd), .sts_i(sts),
    .ent_we_o(ent_we), .ent_idx_o(ent_idx), .bit_we_o(bit_we), .rd_en_o(rd_en)
  );

  cgl_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .ent_we_i(ent_we), .ent_tab_i(target_i), .ent_idx_i(ent_idx),
    .ent_data_i({row_index_i[ParAw-1:0], col_index_i[SrcAw-1:0]}),
    .bit_we_i(bit_we), .bit_vec_i(target_i[1:0]), .bit_addr_i(col_index_i[SrcAw-1:0]),
    .bit_val_i(bit_value_i), .rd_en_i(rd_en), .rd_local_i(target_i[0]),
    .rd_addr_i(row_index_i[ParAw-1:0]), .glen_i(glen_q), .llen_i(llen_q),
    .rd_bit_o(rd_bit)
  );

  assign read_bit_o = rd_pending & rd_bit;

  // A held result keeps its status.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result changed while stalled");
  // No input taken while the result register is stalled full.
  a_nostall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted with full output");
  // A failed transaction never returns a parity bit.
  a_rdzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> !read_bit_o)
    else $error("read bit set with error status");

endmodule

@@ sv/cgl_ram.sv @@
// ---------------------------------------------------------------------------
// cgl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module cgl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/cgl_datapath.sv @@
// ---------------------------------------------------------------------------
// cgl_datapath: table, data and parity stores of the encoder
// Walks table entries under controller command and accumulates source bits
// into the parity stores; serves loads and single-bit parity reads.
// ---------------------------------------------------------------------------
module cgl_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cgl_pkg::cmd_t               cmd_i,
  output cgl_pkg::sts_t               sts_o,
  // Direct load and read access, used when the controller is idle.
  input  logic                        ent_we_i,
  input  logic [2:0]                  ent_tab_i,
  input  logic [cgl_pkg::EntryAw-1:0] ent_idx_i,
  input  logic [cgl_pkg::EntryW-1:0]  ent_data_i,
  input  logic                        bit_we_i,
  input  logic [1:0]                  bit_vec_i,
  input  logic [cgl_pkg::SrcAw-1:0]   bit_addr_i,
  input  logic                        bit_val_i,
  input  logic                        rd_en_i,
  input  logic                        rd_local_i,
  input  logic [cgl_pkg::ParAw-1:0]   rd_addr_i,
  input  logic [cgl_pkg::LenW-1:0]    glen_i,
  input  logic [cgl_pkg::LenW-1:0]    llen_i,
  output logic                        rd_bit_o
);
  import cgl_pkg::*;

  // Entry memory: tables are stacked, one EntryAw-sized region each.
  logic [MemAw-1:0]  ent_waddr, ent_raddr;
  logic [EntryW-1:0] ent_rdata;

  assign ent_waddr = {ent_tab_i, ent_idx_i};
  assign ent_raddr = {cmd_i.tab, cmd_i.idx};

  cgl_ram #(.Width(EntryW), .Depth(TableCount * MaxEntries)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we_i),
    .waddr_i (ent_waddr[$clog2(TableCount * MaxEntries)-1:0]),
    .wdata_i (ent_data_i),
    .raddr_i (ent_raddr[$clog2(TableCount * MaxEntries)-1:0]),
    .rdata_o (ent_rdata)
  );

  // Pipeline control following the entry read.
  logic        s1_valid_q, s2_valid_q;
  src_sel_e    s1_src_q, s2_src_q;
  logic        s1_dst_q, s2_dst_q;
  logic [ParAw-1:0] s2_row_q;
  logic        s2_row_ok_q;
  logic [ParAw:0] dst_len;
  logic [ParAw:0] glen_c, llen_c;

  // Lengths in use, clamped to the store depth.
  assign glen_c = (glen_i > LenW'(MaxParityBits)) ? (ParAw+1)'(MaxParityBits)
                                                   : (ParAw+1)'(glen_i);
  assign llen_c = (llen_i > LenW'(MaxParityBits)) ? (ParAw+1)'(MaxParityBits)
                                                   : (ParAw+1)'(llen_i);

  // Entry fields as read back from memory in stage 1.
  logic [ParAw-1:0] e_row;
  logic [SrcAw-1:0] e_col;
  assign e_row = ent_rdata[EntryW-1 -: ParAw];
  assign e_col = ent_rdata[SrcAw-1:0];
  assign dst_len = s1_dst_q ? llen_c : glen_c;

  // Source bit memories, each with one read port addressed by the entry column.
  logic sys_rd, fst_rd, snd_rd;
  cgl_ram #(.Width(1), .Depth(MaxSourceBits)) u_sys_ram (
    .clk_i(clk_i), .we_i(bit_we_i && bit_vec_i == 2'(VecSys)), .waddr_i(bit_addr_i),
    .wdata_i(bit_val_i), .raddr_i(e_col), .rdata_o(sys_rd));
  cgl_ram #(.Width(1), .Depth(MaxSourceBits)) u_fst_ram (
    .clk_i(clk_i), .we_i(bit_we_i && bit_vec_i == 2'(VecFirst)), .waddr_i(bit_addr_i),
    .wdata_i(bit_val_i), .raddr_i(e_col), .rdata_o(fst_rd));
  cgl_ram #(.Width(1), .Depth(MaxSourceBits)) u_snd_ram (
    .clk_i(clk_i), .we_i(bit_we_i && bit_vec_i == 2'(VecSecond)), .waddr_i(bit_addr_i),
    .wdata_i(bit_val_i), .raddr_i(e_col), .rdata_o(snd_rd));

  // Parity stores, small enough to keep in flip-flops with one
  // read-modify-write per cycle. A Y source read from the global store.
  logic [MaxParityBits-1:0] gpar_q, lpar_q;
  logic                     gsrc_q;
  logic [ParAw:0]           clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      clr_idx_q  <= '0;
      gpar_q     <= '0;
      lpar_q     <= '0;
    end else begin
      s1_valid_q <= cmd_i.rd_entry;
      s2_valid_q <= s1_valid_q;
      if (cmd_i.clr_start) begin
        clr_idx_q <= '0;
      end else if (cmd_i.clr_step) begin
        gpar_q[clr_idx_q[ParAw-1:0]] <= 1'b0;
        lpar_q[clr_idx_q[ParAw-1:0]] <= 1'b0;
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      // Stage 2: add the fetched source bit into its parity row.
      if (s2_valid_q && s2_row_ok_q) begin
        if (s2_dst_q) begin
          lpar_q[s2_row_q] <= lpar_q[s2_row_q] ^ src_bit(s2_src_q);
        end else begin
          gpar_q[s2_row_q] <= gpar_q[s2_row_q] ^ src_bit(s2_src_q);
        end
      end
    end
  end

  // Stage 1 and stage 2 payload registers.
  always_ff @(posedge clk_i) begin
    s1_src_q    <= cmd_i.src;
    s1_dst_q    <= cmd_i.dst_local;
    s2_src_q    <= s1_src_q;
    s2_dst_q    <= s1_dst_q;
    s2_row_q    <= e_row;
    s2_row_ok_q <= ({1'b0, e_row} < dst_len);
    // Y column reads the global store; beyond the global length it is zero.
    gsrc_q      <= ({1'b0, e_col} < (SrcAw+1)'(glen_c)) ?
                   gpar_q[e_col[ParAw-1:0]] : 1'b0;
  end

  function automatic logic src_bit(src_sel_e s);
    logic b;
    case (s)
      SrcSys:    b = sys_rd;
      SrcFirst:  b = fst_rd;
      SrcSecond: b = snd_rd;
      SrcGlobal: b = gsrc_q;
      default:   b = 1'b0;
    endcase
    return b;
  endfunction

  assign sts_o.clr_last = (clr_idx_q == (ParAw+1)'(MaxParityBits - 1));

  // Parity bit read, registered.
  logic rd_bit_q;
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_bit_q <= rd_local_i ? lpar_q[rd_addr_i] : gpar_q[rd_addr_i];
    end
  end
  assign rd_bit_o = rd_bit_q;

  logic unused_acc;
  assign unused_acc = cmd_i.acc_en;

endmodule

@@ sv/cgl_ctrl.sv @@
// ---------------------------------------------------------------------------
// cgl_ctrl: request controller of the encoder
// Decodes requests, keeps entry counts and sequences the encode passes.
// ---------------------------------------------------------------------------
module cgl_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  req_type_i,
  input  logic [2:0]                  target_i,
  input  logic [11:0]                 row_index_i,
  input  logic [11:0]                 col_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        rd_pending_o,
  input  logic                        local3_i,
  input  logic [cgl_pkg::LenW-1:0]    glen_i,
  input  logic [cgl_pkg::LenW-1:0]    llen_i,
  output cgl_pkg::cmd_t               cmd_o,
  input  cgl_pkg::sts_t               sts_i,
  output logic                        ent_we_o,
  output logic [cgl_pkg::EntryAw-1:0] ent_idx_o,
  output logic                        bit_we_o,
  output logic                        rd_en_o
);
  import cgl_pkg::*;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StClear = 5'b00010,
    StWalk  = 5'b00100,
    StDrain = 5'b01000,
    StResp  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CountW-1:0] cnt_q [TableCount];
  logic [2:0]        pass_q, pass_d;     // index into pass order
  logic [EntryAw:0]  idx_q, idx_d;
  logic [1:0]        drain_q, drain_d;
  logic              ov_q;
  logic [1:0]        st_q;
  logic              rd_pend_q;
  logic              accept;

  // Output register free when empty or being taken.
  logic out_free;
  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = !(state_q == StIdle) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Pass order: V, W, Z, X, Y.
  function automatic logic [2:0] pass_tab(logic [2:0] p);
    logic [2:0] t;
    case (p)
      3'd0:    t = TabV;
      3'd1:    t = TabW;
      3'd2:    t = TabZ;
      3'd3:    t = TabX;
      default: t = TabY;
    endcase
    return t;
  endfunction

  logic [2:0]       cur_tab;
  logic [CountW-1:0] cur_cnt;
  logic              pass_skip;
  assign cur_tab   = pass_tab(pass_q);
  assign cur_cnt   = cnt_q[cur_tab];
  assign pass_skip = (pass_q == 3'd2) && !local3_i;

  // Request decode.
  logic ld_range_bad, ld_full, bit_bad, rd_bad;
  logic [CountW-1:0] tgt_cnt;
  always_comb begin
    tgt_cnt = (target_i < 3'(TableCount)) ? cnt_q[target_i] : '0;
    ld_range_bad = (target_i >= 3'(TableCount)) || (row_index_i >= 12'(MaxParityBits)) ||
                   ((target_i == TabY) ? (col_index_i >= 12'(MaxParityBits))
                                       : ({1'b0, col_index_i} >= 13'(MaxSourceBits)));
    ld_full = (tgt_cnt >= CountW'(MaxEntries));
    bit_bad = (target_i > VecSecond) || ({1'b0, col_index_i} >= 13'(MaxSourceBits));
    rd_bad  = !(((target_i == RdGlobal) && ({1'b0, row_index_i} <
                  ((glen_i > 11'(MaxParityBits)) ? 13'(MaxParityBits) : 13'(glen_i)))) ||
                ((target_i == RdLocal) && ({1'b0, row_index_i} <
                  ((llen_i > 11'(MaxParityBits)) ? 13'(MaxParityBits) : 13'(llen_i)))));
  end

  assign ent_we_o  = accept && (req_type_i == ReqLoadEntry) && !ld_range_bad && !ld_full;
  assign ent_idx_o = tgt_cnt[EntryAw-1:0];
  assign bit_we_o  = accept && (req_type_i == ReqLoadBit) && !bit_bad;
  assign rd_en_o   = accept && (req_type_i == ReqRead) && !rd_bad;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    idx_d   = idx_q;
    drain_d = drain_q;
    cmd_o   = '0;
    cmd_o.tab = cur_tab;
    cmd_o.idx = idx_q[EntryAw-1:0];
    cmd_o.src = (pass_q == 3'd0 || pass_q == 3'd3) ? SrcSys :
                (pass_q == 3'd1) ? SrcFirst : (pass_q == 3'd2) ? SrcSecond : SrcGlobal;
    cmd_o.dst_local = (pass_q >= 3'd3);
    case (state_q)
      StIdle: begin
        if (accept && req_type_i == ReqEncode) begin
          cmd_o.clr_start = 1'b1;
          state_d = StClear;
        end
      end
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StWalk;
          pass_d  = '0;
          idx_d   = '0;
        end
      end
      StWalk: begin
        if (pass_skip || {1'b0, idx_q} >= (EntryAw+1)'(cur_cnt)) begin
          // Let the pipeline empty so Y sees the finished global parity.
          state_d = StDrain;
          drain_d = '0;
        end else begin
          cmd_o.rd_entry = 1'b1;
          cmd_o.acc_en   = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      StDrain: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == 2'd3) begin
          idx_d = '0;
          if (pass_q == 3'd4) begin
            state_d = StResp;
          end else begin
            pass_d  = pass_q + 1'b1;
            state_d = StWalk;
          end
        end
      end
      StResp: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      pass_q    <= '0;
      idx_q     <= '0;
      drain_q   <= '0;
      ov_q      <= 1'b0;
      st_q      <= StOk;
      rd_pend_q <= 1'b0;
      for (int i = 0; i < TableCount; i++) cnt_q[i] <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      idx_q   <= idx_d;
      drain_q <= drain_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      // Result of a transaction other than encode.
      if (accept && req_type_i != ReqEncode) begin
        ov_q      <= 1'b1;
        rd_pend_q <= (req_type_i == ReqRead) && !rd_bad;
        case (req_type_i)
          ReqLoadEntry: st_q <= ld_range_bad ? StRange : (ld_full ? StFull : StOk);
          ReqLoadBit:   st_q <= bit_bad ? StRange : StOk;
          ReqRead:      st_q <= rd_bad ? StRange : StOk;
          ReqClear:     st_q <= StOk;
          default:      st_q <= StRange;
        endcase
      end
      if (state_q == StResp && out_free) begin
        ov_q      <= 1'b1;
        rd_pend_q <= 1'b0;
        st_q      <= StOk;
      end
      if (ent_we_o) cnt_q[target_i] <= cnt_q[target_i] + 1'b1;
      if (accept && req_type_i == ReqClear) begin
        for (int i = 0; i < TableCount; i++) cnt_q[i] <= '0;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign status_o     = st_q;
  assign rd_pending_o = rd_pend_q;

endmodule

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: testbench of the coupled global/local LDPC encoder
// A queue-fed driver sends load, encode, read and clear requests in random
// bursts, while a monitor stalls the result side on its own pattern and
// checks every result against an in-bench model of the sparse GF(2) encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cgl_pkg::*;

  localparam int WatchdogLimit = 200000;

  typedef struct {
    logic [2:0]  req;
    logic [2:0]  tgt;
    logic [11:0] row;
    logic [11:0] col;
    logic        bitv;
  } enc_req_t;

  typedef struct {
    logic       rd;
    logic [1:0] st;
  } enc_rsp_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [2:0]          req_type_i;
  logic [2:0]          target_i;
  logic [11:0]         row_index_i;
  logic [11:0]         col_index_i;
  logic                bit_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                read_bit_o;
  logic [1:0]          status_o;

  coupled_global_local_ldpc_encoder DUT (.*);

  // Requests waiting for the driver and responses waiting for the monitor.
  enc_req_t pending_reqs[$];
  enc_rsp_t expected_rsps[$];
  int       error_count;
  int       idle_cycles;

  // Encoder model state.
  logic [9:0]  tab_rows [TableCount][MaxEntries];
  logic [11:0] tab_cols [TableCount][MaxEntries];
  int          tab_count [TableCount];
  logic        sys_bits [MaxSourceBits];
  logic        first_bits [MaxSourceBits];
  logic        second_bits [MaxSourceBits];
  logic        gpar [MaxParityBits];
  logic        lpar [MaxParityBits];
  int          m_local_count;
  int          m_glen;
  int          m_llen;

  // Columns already written per data vector, used while generating stimulus.
  int written_cols [3][$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clamp_len(int v);
    return (v > MaxParityBits) ? MaxParityBits : v;
  endfunction

  function automatic logic src_bit(src_sel_e s, int c);
    case (s)
      SrcSys:    return sys_bits[c];
      SrcFirst:  return first_bits[c];
      SrcSecond: return second_bits[c];
      default:   return (c < MaxParityBits) ? gpar[c] : 1'b0;
    endcase
  endfunction

  // XOR the selected source bits into one parity store for every table entry whose row is below the length.
  task automatic accumulate(int tab, src_sel_e s, bit to_local, int len);
    int r;
    int c;
    for (int k = 0; k < tab_count[tab]; k++) begin
      r = tab_rows[tab][k];
      c = tab_cols[tab][k];
      if (r < len) begin
        if (to_local) lpar[r] ^= src_bit(s, c);
        else gpar[r] ^= src_bit(s, c);
      end
    end
  endtask

  // Apply one request to the model and return its response.
  task automatic model_request(enc_req_t t, output enc_rsp_t rsp);
    int glen;
    int llen;
    int tab;
    glen = clamp_len(m_glen);
    llen = clamp_len(m_llen);
    rsp.rd = 1'b0;
    rsp.st = StOk;
    case (t.req)
      ReqLoadEntry: begin
        tab = t.tgt;
        if (t.tgt > TabZ || t.row >= MaxParityBits ||
            (t.tgt == TabY && t.col >= MaxParityBits)) begin
          rsp.st = StRange;
        end else if (tab_count[tab] >= MaxEntries) begin
          rsp.st = StFull;
        end else begin
          tab_rows[tab][tab_count[tab]] = t.row[9:0];
          tab_cols[tab][tab_count[tab]] = t.col;
          tab_count[tab]++;
        end
      end
      ReqLoadBit: begin
        if (t.tgt > VecSecond) rsp.st = StRange;
        else if (t.tgt == VecSys) sys_bits[t.col] = t.bitv;
        else if (t.tgt == VecFirst) first_bits[t.col] = t.bitv;
        else second_bits[t.col] = t.bitv;
      end
      ReqEncode: begin
        for (int i = 0; i < MaxParityBits; i++) begin
          gpar[i] = 1'b0;
          lpar[i] = 1'b0;
        end
        accumulate(TabV, SrcSys, 1'b0, glen);
        accumulate(TabW, SrcFirst, 1'b0, glen);
        if (m_local_count == 3) accumulate(TabZ, SrcSecond, 1'b0, glen);
        accumulate(TabX, SrcSys, 1'b1, llen);
        accumulate(TabY, SrcGlobal, 1'b1, llen);
      end
      ReqRead: begin
        if (t.tgt == RdGlobal && t.row < glen) rsp.rd = gpar[t.row];
        else if (t.tgt == RdLocal && t.row < llen) rsp.rd = lpar[t.row];
        else rsp.st = StRange;
      end
      ReqClear: begin
        for (int i = 0; i < TableCount; i++) tab_count[i] = 0;
      end
      default: rsp.st = StRange;
    endcase
  endtask

  // Driver: sends queued requests in bursts with random gaps.
  enc_req_t on_bus;
  int       burst_left = 5;
  int       gap_left = 0;

  always @(posedge clk_i) begin
    enc_rsp_t rsp;
    logic     nxt_valid;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        model_request(on_bus, rsp);
        expected_rsps.push_back(rsp);
      end
      if (!(in_valid_i && in_stall_o)) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          on_bus = pending_reqs.pop_front();
          nxt_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid_i  <= nxt_valid;
        req_type_i  <= on_bus.req;
        target_i    <= on_bus.tgt;
        row_index_i <= on_bus.row;
        col_index_i <= on_bus.col;
        bit_value_i <= on_bus.bitv;
      end
    end
  end

  // Monitor: checks each accepted response and drives the stall pattern.
  int cycle_no = 0;

  always @(posedge clk_i) begin
    enc_rsp_t exp_rsp;
    int       mode;
    if (rst_ni) begin
      cycle_no++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with nothing expected: read_bit %b status %0d",
                   $time, read_bit_o, status_o);
          error_count++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (read_bit_o !== exp_rsp.rd) begin
            $display("%0t: read_bit expected %b actual %b", $time, exp_rsp.rd, read_bit_o);
            error_count++;
          end
          if (status_o !== exp_rsp.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_rsp.st, status_o);
            error_count++;
          end
        end
      end
      mode = (cycle_no / 97) % 3;
      if (mode == 0) out_stall_i <= 1'b0;
      else if (mode == 1) out_stall_i <= ($urandom_range(0, 2) == 0);
      else out_stall_i <= ((cycle_no % 5) < 2);
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_req(logic [2:0] req, logic [2:0] tgt, logic [11:0] row,
                         logic [11:0] col, logic bitv);
    enc_req_t t;
    t.req = req;
    t.tgt = tgt;
    t.row = row;
    t.col = col;
    t.bitv = bitv;
    pending_reqs.push_back(t);
  endtask

  task automatic load_bit(logic [2:0] vec, logic [11:0] col, logic bitv);
    add_req(ReqLoadBit, vec, 12'($urandom_range(0, 4095)), col, bitv);
    if (vec <= VecSecond) written_cols[vec].push_back(col);
  endtask

  // A column whose source bit has been written, for the given table; for Y a random parity index.
  function automatic logic [11:0] pick_col(logic [2:0] tab);
    int v;
    if (tab == TabY) return 12'($urandom_range(0, MaxParityBits - 1));
    v = (tab == TabW) ? VecFirst : (tab == TabZ) ? VecSecond : VecSys;
    return 12'(written_cols[v][$urandom_range(0, written_cols[v].size() - 1)]);
  endfunction

  task automatic add_entry(logic [2:0] tab, logic [11:0] row);
    add_req(ReqLoadEntry, tab, row, pick_col(tab), 1'($urandom));
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgLocalCount) m_local_count = data[1:0];
    else if (idx == CfgGlobalLen) m_glen = data;
    else if (idx == CfgLocalLen) m_llen = data;
  endtask

  // Well-formed episodes: data loads, a few entries, encode, reads; noise too.
  task automatic random_episodes(int n_items);
    int done_items;
    int n;
    int kind;
    logic [2:0] tab;
    done_items = 0;
    while (done_items < n_items) begin
      n = $urandom_range(2, 8);
      for (int i = 0; i < n; i++)
        load_bit(3'($urandom_range(0, 2)), 12'($urandom_range(0, 4095)), 1'($urandom));
      done_items += n;
      n = $urandom_range(3, 12);
      for (int i = 0; i < n; i++) begin
        tab = 3'($urandom_range(0, 4));
        add_entry(tab, ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 1023))
                                                   : 12'($urandom_range(0, 63)));
      end
      done_items += n;
      add_req(ReqEncode, 3'($urandom), 12'($urandom), 12'($urandom), 1'($urandom));
      n = $urandom_range(4, 12);
      for (int i = 0; i < n; i++)
        add_req(ReqRead, 3'($urandom_range(0, 1)),
                ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63)),
                12'($urandom), 1'($urandom));
      done_items += n + 1;
      // Occasional noise: bad targets, bad requests, out-of-range entries.
      if ($urandom_range(0, 1) == 0) begin
        kind = $urandom_range(0, 3);
        if (kind == 0) add_req(3'($urandom_range(5, 7)), 3'($urandom), 12'($urandom),
                               12'($urandom), 1'($urandom));
        else if (kind == 1) add_req(ReqLoadBit, 3'($urandom_range(3, 7)), 12'($urandom),
                                    12'($urandom), 1'($urandom));
        else if (kind == 2) add_req(ReqLoadEntry, 3'($urandom_range(0, 4)),
                                    12'($urandom_range(1024, 4095)), 12'($urandom),
                                    1'($urandom));
        else add_req(ReqLoadEntry, TabY, 12'($urandom_range(0, 1023)),
                     12'($urandom_range(1024, 4095)), 1'($urandom));
        done_items++;
      end
      if ($urandom_range(0, 3) == 0) begin
        add_req(ReqClear, 3'($urandom), 12'($urandom), 12'($urandom), 1'($urandom));
        done_items++;
      end
    end
  endtask

  // Stimulus and phase control.
  initial begin
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = '0;
    target_i = '0;
    row_index_i = '0;
    col_index_i = '0;
    bit_value_i = 1'b0;
    out_stall_i = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    on_bus = '{default: '0};
    for (int i = 0; i < TableCount; i++) tab_count[i] = 0;
    for (int i = 0; i < MaxParityBits; i++) begin
      gpar[i] = 1'b0;
      lpar[i] = 1'b0;
    end
    m_local_count = 2;
    m_glen = 1024;
    m_llen = 1024;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, each request, bad targets and ranges.
    add_req(ReqRead, RdGlobal, 12'd0, 12'd0, 1'b0);
    add_req(ReqRead, RdLocal, 12'd1023, 12'hFFF, 1'b1);
    add_req(ReqRead, RdLocal, 12'd1024, 12'd0, 1'b0);
    add_req(ReqRead, 3'd7, 12'd0, 12'd0, 1'b0);
    load_bit(VecSys, 12'd0, 1'b1);
    load_bit(VecSys, 12'd4095, 1'b1);
    load_bit(VecFirst, 12'd4095, 1'b1);
    load_bit(VecFirst, 12'd0, 1'b0);
    load_bit(VecSecond, 12'd2048, 1'b1);
    add_req(ReqLoadBit, 3'd7, 12'hFFF, 12'd5, 1'b1);
    add_req(ReqLoadEntry, TabV, 12'd1023, 12'd4095, 1'b0);
    add_req(ReqLoadEntry, TabX, 12'd0, 12'd0, 1'b0);
    add_req(ReqLoadEntry, TabW, 12'd0, 12'd4095, 1'b0);
    add_req(ReqLoadEntry, TabZ, 12'd5, 12'd2048, 1'b0);
    add_req(ReqLoadEntry, TabY, 12'd0, 12'd1023, 1'b0);
    add_req(ReqLoadEntry, TabY, 12'd1, 12'd1024, 1'b0);
    add_req(ReqLoadEntry, TabV, 12'd1024, 12'd0, 1'b0);
    add_req(ReqLoadEntry, TabX, 12'd4095, 12'd0, 1'b0);
    add_req(ReqLoadEntry, 3'd5, 12'd0, 12'd0, 1'b0);
    add_req(ReqEncode, 3'd0, 12'd0, 12'd0, 1'b0);
    add_req(ReqRead, RdGlobal, 12'd1023, 12'd0, 1'b0);
    add_req(ReqRead, RdLocal, 12'd0, 12'd0, 1'b0);
    add_req(3'd7, 3'd0, 12'd0, 12'd0, 1'b0);
    add_req(3'd5, 3'd7, 12'hFFF, 12'hFFF, 1'b1);
    add_req(ReqClear, 3'd0, 12'd0, 12'd0, 1'b0);
    wait_idle();

    // Full table: fill W to capacity, one more gives a full status.
    for (int i = 0; i < MaxEntries; i++) add_entry(TabW, 12'($urandom_range(0, 1023)));
    add_entry(TabW, 12'd3);
    add_req(ReqLoadEntry, TabW, 12'd2000, 12'd0, 1'b0);
    add_req(ReqEncode, 3'd0, 12'd0, 12'd0, 1'b0);
    for (int i = 0; i < 4; i++)
      add_req(ReqRead, 3'($urandom_range(0, 1)), 12'($urandom_range(0, 1023)), 12'd0, 1'b0);
    add_req(ReqClear, 3'd0, 12'd0, 12'd0, 1'b0);
    random_episodes(350);
    wait_idle();

    // Three-local mode with lengths of one.
    cfg_write(CfgLocalCount, 11'd3);
    cfg_write(CfgGlobalLen, 11'd1);
    cfg_write(CfgLocalLen, 11'd1);
    random_episodes(350);
    wait_idle();

    // Three-local mode, odd lengths.
    cfg_write(CfgGlobalLen, 11'd37);
    cfg_write(CfgLocalLen, 11'd50);
    random_episodes(400);
    wait_idle();

    // Other local count values fall back to two-local; global length above the clamp, local length at it.
    cfg_write(CfgLocalCount, 11'h7FC);
    cfg_write(CfgGlobalLen, 11'h7FF);
    cfg_write(CfgLocalLen, 11'd1024);
    random_episodes(350);
    wait_idle();

    cfg_write(CfgLocalCount, 11'd1);
    cfg_write(CfgGlobalLen, 11'd1024);
    cfg_write(CfgLocalLen, 11'h7FF);
    random_episodes(200);
    wait_idle();

    cfg_write(CfgLocalCount, 11'd3);
    cfg_write(CfgGlobalLen, 11'd64);
    cfg_write(CfgLocalLen, 11'd32);
    random_episodes(250);
    wait_idle();
    repeat (50) @(posedge clk_i);

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
sv/cgl_pkg.sv
sv/cgl_ram.sv
sv/cgl_datapath.sv
sv/cgl_ctrl.sv
sv/coupled_global_local_ldpc_encoder.sv
sim/tb_top.sv
